FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the clocked, reset-qualified property checks used in RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while reset is released.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while reset is released.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/stoi_pkg.sv
// ----------------------------------------------------------------------------
// stoi_pkg
// Shared types and character/base constants of the string-to-integer parser.
// ----------------------------------------------------------------------------
package stoi_pkg;

    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 6;
    localparam int OUT_VALUE_W  = 64;
    localparam int OUT_OFFSET_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_X_LO  = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_Z_LO  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z_UP  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] NO_DIGIT  = 6'd63;

    typedef struct packed {
        logic              is_space;
        logic              is_sign;
        logic              is_minus;
        logic              is_zero;
        logic              is_x;
        logic [BASE_W-1:0] digit;
    } t_char_class;

endpackage

FILE: sv/stoi_char_class.sv
// ----------------------------------------------------------------------------
// stoi_char_class
// Classifies one character: whitespace, sign, zero, x, and its digit value.
// ----------------------------------------------------------------------------
module stoi_char_class (
    input  logic [stoi_pkg::CHAR_W-1:0] i_char,
    output stoi_pkg::t_char_class       o_class
);
    import stoi_pkg::*;

    always_comb begin
        o_class.is_space = (i_char == CHAR_SPACE) ||
                           ((i_char >= CHAR_TAB) && (i_char <= CHAR_CR));
        o_class.is_sign  = (i_char == CHAR_MINUS) || (i_char == CHAR_PLUS);
        o_class.is_minus = (i_char == CHAR_MINUS);
        o_class.is_zero  = (i_char == CHAR_ZERO);
        o_class.is_x     = (i_char == CHAR_X_LO) || (i_char == CHAR_X_UP);
        o_class.digit    = NO_DIGIT;
        if ((i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE)) begin
            o_class.digit = BASE_W'(i_char - CHAR_ZERO);
        end else if ((i_char >= CHAR_A_LO) && (i_char <= CHAR_Z_LO)) begin
            o_class.digit = BASE_W'(i_char - CHAR_A_LO + CHAR_W'(10));
        end else if ((i_char >= CHAR_A_UP) && (i_char <= CHAR_Z_UP)) begin
            o_class.digit = BASE_W'(i_char - CHAR_A_UP + CHAR_W'(10));
        end
    end

endmodule

FILE: sv/stoi_mac.sv
// ----------------------------------------------------------------------------
// stoi_mac
// One multiply-accumulate step, acc * base + digit, with a range check.
// ----------------------------------------------------------------------------
module stoi_mac #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic [VALUE_WIDTH-1:0]      i_acc,
    input  logic [stoi_pkg::BASE_W-1:0] i_base,
    input  logic [stoi_pkg::BASE_W-1:0] i_digit,
    input  logic                        i_negative,
    output logic [VALUE_WIDTH-1:0]      o_sum,
    output logic                        o_overflow
);
    import stoi_pkg::*;

    localparam int SUM_W = VALUE_WIDTH + BASE_W + 1;

    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_half;
    logic [SUM_W-1:0] w_limit;

    // The negative side reaches one step further than the positive side.
    assign w_half     = SUM_W'(1) << (VALUE_WIDTH - 1);
    assign w_limit    = i_negative ? w_half : (w_half - SUM_W'(1));
    assign w_sum      = (SUM_W'(i_acc) * SUM_W'(i_base)) + SUM_W'(i_digit);
    assign o_overflow = (w_sum > w_limit);
    assign o_sum      = w_sum[VALUE_WIDTH-1:0];

endmodule

FILE: sv/string_to_signed_integer_parser_core.sv
// ----------------------------------------------------------------------------
// string_to_signed_integer_parser_core
// Streaming strtol: one character per transaction in, one result per string.
// ----------------------------------------------------------------------------
// The core accepts one character in every clock cycle while the result
// slot is free. A character is held in the input register, and the step
// logic then writes the result register when the string ends. The
// rate is set by the parse-state loop, whose critical path is the
// VALUE_WIDTH by 6-bit multiply-accumulate of the digit accumulator and its
// compare against the signed limit. While a finished result waits for the
// downstream side, the input register holds at most one more character and
// the character stream is stalled until the result transaction is taken.
// There is no clearing pass after reset.
`include "assert_macros.svh"

module string_to_signed_integer_parser_core #(
    parameter int VALUE_WIDTH  = 64,
    parameter int OFFSET_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: radix 2..36, or 0 for detection from the prefix.
    input  logic        i_cfg_wr_en,
    input  logic [5:0]  i_cfg_wr_data,
    // Character stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tuser,   // [0] first
    input  logic        s_axis_tlast,   // last character of the string
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [63:0] value, [79:64] end_offset
    output logic [1:0]  m_axis_tuser    // [0] overflowed, [1] converted
);
    import stoi_pkg::*;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    function automatic logic [OFFSET_WIDTH-1:0] offset_inc(input logic [OFFSET_WIDTH-1:0] p);
        return (&p) ? p : (p + OFFSET_WIDTH'(1));
    endfunction

    // Input register.
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_first;
    logic              r_in_last;

    // Configuration and parse state.
    logic [BASE_W-1:0]       r_number_base;
    t_phase                  r_phase,    n_phase;
    logic                    r_neg,      n_neg;
    logic [VALUE_WIDTH-1:0]  r_acc,      n_acc;
    logic                    r_ovs,      n_ovs;
    logic [BASE_W-1:0]       r_ab,       n_ab;
    logic [OFFSET_WIDTH-1:0] r_pos,      n_pos;
    logic [OFFSET_WIDTH-1:0] r_fb,       n_fb;

    // Result register.
    logic                    r_out_valid, n_out_valid;
    logic [79:0]             r_out_tdata, n_out_tdata;
    logic [1:0]              r_out_tuser, n_out_tuser;

    logic                    w_out_free;
    logic                    w_step;
    t_char_class             w_class;
    t_phase                  w_ph0;
    logic                    w_neg0;
    logic [VALUE_WIDTH-1:0]  w_acc0;
    logic                    w_ovs0;
    logic [OFFSET_WIDTH-1:0] w_pos0;
    logic [OFFSET_WIDTH-1:0] w_fb0;
    logic [BASE_W-1:0]       w_sign_base;
    logic                    w_base_ok;
    logic [BASE_W-1:0]       w_eff_base;
    logic [BASE_W-1:0]       w_zero_base;
    logic [BASE_W-1:0]       w_mac_base;
    logic [VALUE_WIDTH-1:0]  w_mac_sum;
    logic                    w_mac_ovf;

    // A result slot is free when empty or being drained this cycle; the input
    // register refills whenever it is empty or moves into the step logic.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    stoi_char_class u_class (
        .i_char  (r_in_char),
        .o_class (w_class)
    );

    // A first marker restarts the string before the character is looked at.
    assign w_ph0  = r_in_first ? PH_SPACE : r_phase;
    assign w_neg0 = r_in_first ? 1'b0 : r_neg;
    assign w_acc0 = r_in_first ? '0 : r_acc;
    assign w_ovs0 = r_in_first ? 1'b0 : r_ovs;
    assign w_pos0 = r_in_first ? '0 : r_pos;
    assign w_fb0  = r_in_first ? '0 : r_fb;

    // The base is sampled from the register while whitespace is skipped.
    assign w_sign_base = (w_ph0 == PH_SPACE) ? r_number_base : r_ab;
    assign w_base_ok   = (w_sign_base == BASE_AUTO) ||
                         ((w_sign_base >= BASE_MIN) && (w_sign_base <= BASE_MAX));
    assign w_eff_base  = (w_sign_base == BASE_AUTO) ? BASE_DEC : w_sign_base;
    assign w_zero_base = (r_ab == BASE_AUTO) ? BASE_OCT : r_ab;

    // Only one digit can be accumulated per character, so one multiplier
    // serves every phase; its base follows the phase the character lands in.
    always_comb begin
        unique case (w_ph0)
            PH_ZERO:   w_mac_base = w_zero_base;
            PH_PREFIX: w_mac_base = BASE_HEX;
            PH_DIGITS: w_mac_base = r_ab;
            default:   w_mac_base = w_eff_base;
        endcase
    end

    stoi_mac #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mac (
        .i_acc      (w_acc0),
        .i_base     (w_mac_base),
        .i_digit    (w_class.digit),
        .i_negative (w_neg0),
        .o_sum      (w_mac_sum),
        .o_overflow (w_mac_ovf)
    );

    // Step logic: advances the parse state by one character and, when the
    // string ends here, builds the result transaction.
    always_comb begin
        t_phase                         ph;
        logic                           neg;
        logic [VALUE_WIDTH-1:0]         acc;
        logic                           ovs;
        logic [BASE_W-1:0]              ab;
        logic [OFFSET_WIDTH-1:0]        pos;
        logic [OFFSET_WIDTH-1:0]        fb;
        logic                           do_acc;
        logic                           emit;
        logic                           conv;
        logic [OFFSET_WIDTH-1:0]        endo;
        logic [VALUE_WIDTH-1:0]         half;
        logic signed [VALUE_WIDTH-1:0]  v;

        ph        = w_ph0;
        neg       = w_neg0;
        acc       = w_acc0;
        ovs       = w_ovs0;
        ab        = r_ab;
        pos       = w_pos0;
        fb        = w_fb0;
        do_acc    = 1'b0;
        emit      = 1'b0;
        conv      = 1'b0;
        endo      = '0;
        half      = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);
        v         = '0;

        n_phase     = r_phase;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_ovs       = r_ovs;
        n_ab        = r_ab;
        n_pos       = r_pos;
        n_fb        = r_fb;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_tdata = r_out_tdata;
        n_out_tuser = r_out_tuser;

        if (w_step) begin
            if (ph != PH_DONE) begin
                unique case (ph)
                    PH_SPACE, PH_SIGN: begin
                        if (ph == PH_SPACE) begin
                            ab = r_number_base;
                        end
                        if ((ph == PH_SPACE) && w_class.is_space) begin
                            ph = PH_SPACE;
                        end else if ((ph == PH_SPACE) && w_class.is_sign) begin
                            neg = w_class.is_minus;
                            ph  = PH_SIGN;
                        end else if (w_base_ok && w_class.is_zero &&
                                     ((w_sign_base == BASE_AUTO) ||
                                      (w_sign_base == BASE_HEX))) begin
                            ph = PH_ZERO;
                            fb = offset_inc(pos);
                        end else if (w_base_ok && (w_class.digit < w_eff_base)) begin
                            ab     = w_eff_base;
                            do_acc = 1'b1;
                            ph     = PH_DIGITS;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (w_class.is_x) begin
                            ab = BASE_HEX;
                            ph = PH_PREFIX;
                        end else begin
                            ab = w_zero_base;
                            ph = PH_DIGITS;
                            if (w_class.digit < w_zero_base) begin
                                do_acc = 1'b1;
                            end else begin
                                emit = 1'b1;
                                conv = 1'b1;
                                endo = pos;
                            end
                        end
                    end
                    PH_PREFIX: begin
                        if (w_class.digit < BASE_HEX) begin
                            do_acc = 1'b1;
                            ph     = PH_DIGITS;
                        end else begin
                            // Bare prefix: only the leading zero counts.
                            emit = 1'b1;
                            conv = 1'b1;
                            endo = fb;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_class.digit < r_ab) begin
                            do_acc = 1'b1;
                        end else begin
                            emit = 1'b1;
                            conv = 1'b1;
                            endo = pos;
                        end
                    end
                    default: begin
                        ph = r_phase;
                    end
                endcase

                // Once out of range the accumulator freezes and the flag holds.
                if (do_acc && !ovs) begin
                    if (w_mac_ovf) begin
                        ovs = 1'b1;
                    end else begin
                        acc = w_mac_sum;
                    end
                end

                // The last character closes whatever is still open.
                if (!emit && r_in_last) begin
                    emit = 1'b1;
                    priority case (ph)
                        PH_SPACE, PH_SIGN: begin
                            conv = 1'b0;
                        end
                        PH_PREFIX: begin
                            conv = 1'b1;
                            endo = fb;
                        end
                        default: begin
                            conv = 1'b1;
                            endo = offset_inc(pos);
                        end
                    endcase
                end

                if (emit) begin
                    ph = PH_DONE;
                    if (conv) begin
                        if (ovs) begin
                            v = neg ? half : (half - VALUE_WIDTH'(1));
                        end else begin
                            v = neg ? (VALUE_WIDTH'(0) - acc) : acc;
                        end
                    end
                    n_out_valid = 1'b1;
                    n_out_tdata = {OUT_OFFSET_W'(endo), OUT_VALUE_W'(v)};
                    n_out_tuser = {conv, conv && ovs};
                end

                pos = offset_inc(pos);
            end

            n_phase = ph;
            n_neg   = neg;
            n_acc   = acc;
            n_ovs   = ovs;
            n_ab    = ab;
            n_pos   = pos;
            n_fb    = fb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_number_base <= BASE_DEC;
            r_phase       <= PH_SPACE;
            r_neg         <= 1'b0;
            r_acc         <= '0;
            r_ovs         <= 1'b0;
            r_ab          <= BASE_DEC;
            r_pos         <= '0;
            r_fb          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (i_cfg_wr_en) begin
                r_number_base <= i_cfg_wr_data;
            end
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_ovs       <= n_ovs;
            r_ab        <= n_ab;
            r_pos       <= n_pos;
            r_fb        <= n_fb;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
            r_in_last  <= s_axis_tlast;
        end
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

    // An overflow is only ever reported together with a conversion.
    `ASSERT_IMPLIES(a_ovf_needs_conv, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[1], "overflow without conversion")

    // A result with nothing converted carries zero value and zero offset.
    `ASSERT_IMPLIES(a_noconv_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata == 80'd0, "nonzero empty result")

    // A finished string stays silent until the next first marker.
    `ASSERT_NEXT(a_done_silent, i_clk, i_rst_n,
        w_step && (r_phase == PH_DONE) && !r_in_first, !m_axis_tvalid, "result after end")

    // The last character of an open string always produces a result.
    `ASSERT_NEXT(a_last_emits, i_clk, i_rst_n,
        w_step && r_in_last && ((r_phase != PH_DONE) || r_in_first), m_axis_tvalid,
        "last character gave no result")

endmodule

FILE: tb/strtol_result_checker.sv
// ----------------------------------------------------------------------------
// strtol_result_checker
// Watches the character, result and configuration ports of the parser,
// predicts the result of every string and compares it field by field.
// ----------------------------------------------------------------------------
module strtol_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [5:0]  i_cfg_wr_data,
    input  logic        i_char_valid,
    input  logic        i_char_ready,
    input  logic [7:0]  i_char_data,
    input  logic        i_char_first,
    input  logic        i_char_last,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [79:0] i_res_data,     // [63:0] value, [79:64] end_offset
    input  logic [1:0]  i_res_flags,    // [0] overflowed, [1] converted
    output int          o_mismatches,
    output int          o_pending
);
    import stoi_pkg::*;

    typedef enum logic [2:0] {
        SCAN_BLANK,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_PREFIX,
        SCAN_DIGITS,
        SCAN_DONE
    } t_scan_phase;

    typedef struct packed {
        logic [63:0] value;
        logic        overflowed;
        logic        converted;
        logic [15:0] end_offset;
    } t_conversion;

    localparam logic [63:0] POS_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT  = 64'h8000_0000_0000_0000;
    localparam logic [15:0] OFFSET_TOP = 16'hFFFF;

    logic [5:0]  radix_reg;
    t_scan_phase phase;
    bit          negative;
    logic [63:0] magnitude;
    bit          saturated;
    logic [5:0]  string_radix;
    logic [15:0] char_pos;
    logic [15:0] zero_end;
    int          mismatch_total = 0;

    t_conversion expected_conversions[$];

    function automatic logic [5:0] char_digit(logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return 6'(c - CHAR_ZERO);
        if (c >= CHAR_A_LO && c <= CHAR_Z_LO) return 6'(c - CHAR_A_LO) + 6'd10;
        if (c >= CHAR_A_UP && c <= CHAR_Z_UP) return 6'(c - CHAR_A_UP) + 6'd10;
        return NO_DIGIT;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic [15:0] next_pos(logic [15:0] p);
        return (p == OFFSET_TOP) ? p : p + 16'd1;
    endfunction

    // The magnitude stops growing once it would pass the limit of its sign.
    task automatic add_digit(input logic [5:0] d, input logic [5:0] radix);
        logic [63:0] bound;
        bound = negative ? NEG_LIMIT : POS_LIMIT;
        if (!saturated) begin
            if (magnitude > (bound - 64'(d)) / 64'(radix))
                saturated = 1'b1;
            else
                magnitude = magnitude * 64'(radix) + 64'(d);
        end
    endtask

    function automatic t_conversion close_string(bit conv, logic [15:0] end_pos);
        t_conversion r;
        r = '0;
        if (conv) begin
            r.overflowed = saturated;
            if (saturated)
                r.value = negative ? NEG_LIMIT : POS_LIMIT;
            else
                r.value = negative ? (64'd0 - magnitude) : magnitude;
            r.converted  = 1'b1;
            r.end_offset = end_pos;
        end
        phase = SCAN_DONE;
        return r;
    endfunction

    task automatic parse_char(input logic [7:0] c, input logic first, input logic last,
                              output bit produced, output t_conversion res);
        logic [5:0] d;
        logic [5:0] eff;
        bit         used;
        bit         radix_ok;
        d        = char_digit(c);
        used     = 1'b0;
        produced = 1'b0;
        res      = '0;
        if (first) begin
            phase     = SCAN_BLANK;
            negative  = 1'b0;
            magnitude = '0;
            saturated = 1'b0;
            char_pos  = '0;
            zero_end  = '0;
        end
        if (phase != SCAN_DONE) begin
            if (phase == SCAN_BLANK) begin
                string_radix = radix_reg;
                if (is_blank(c)) begin
                    used = 1'b1;
                end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                    negative = (c == CHAR_MINUS);
                    phase    = SCAN_SIGN;
                    used     = 1'b1;
                end else begin
                    phase = SCAN_SIGN;
                end
            end
            if (!used && phase == SCAN_SIGN) begin
                radix_ok = (string_radix == BASE_AUTO) ||
                           (string_radix >= BASE_MIN && string_radix <= BASE_MAX);
                eff = (string_radix == BASE_AUTO) ? BASE_DEC : string_radix;
                if (radix_ok && c == CHAR_ZERO &&
                    (string_radix == BASE_AUTO || string_radix == BASE_HEX)) begin
                    phase    = SCAN_ZERO;
                    zero_end = next_pos(char_pos);
                    used     = 1'b1;
                end else if (radix_ok && d < eff) begin
                    string_radix = eff;
                    add_digit(d, eff);
                    phase = SCAN_DIGITS;
                    used  = 1'b1;
                end else begin
                    res      = close_string(1'b0, '0);
                    produced = 1'b1;
                end
            end
            if (!used && phase == SCAN_ZERO) begin
                if (c == CHAR_X_LO || c == CHAR_X_UP) begin
                    string_radix = BASE_HEX;
                    phase        = SCAN_PREFIX;
                    used         = 1'b1;
                end else begin
                    if (string_radix == BASE_AUTO) string_radix = BASE_OCT;
                    phase = SCAN_DIGITS;
                end
            end
            if (!used && phase == SCAN_PREFIX) begin
                if (d < BASE_HEX) begin
                    add_digit(d, BASE_HEX);
                    phase = SCAN_DIGITS;
                    used  = 1'b1;
                end else begin
                    // A bare prefix counts only its zero as converted.
                    res      = close_string(1'b1, zero_end);
                    produced = 1'b1;
                end
            end
            if (!used && phase == SCAN_DIGITS) begin
                if (d < string_radix) begin
                    add_digit(d, string_radix);
                end else begin
                    res      = close_string(1'b1, char_pos);
                    produced = 1'b1;
                end
            end
            if (phase != SCAN_DONE && last) begin
                if (phase == SCAN_BLANK || phase == SCAN_SIGN)
                    res = close_string(1'b0, '0);
                else if (phase == SCAN_PREFIX)
                    res = close_string(1'b1, zero_end);
                else
                    res = close_string(1'b1, next_pos(char_pos));
                produced = 1'b1;
            end
            char_pos = next_pos(char_pos);
        end
    endtask

    task automatic report_mismatch(string field, logic [63:0] seen, logic [63:0] wanted);
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, seen, wanted);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin : watch
        t_conversion predicted;
        t_conversion seen;
        t_conversion wanted;
        bit          produced;
        if (!i_rst_n) begin
            radix_reg    = BASE_DEC;
            phase        = SCAN_BLANK;
            negative     = 1'b0;
            magnitude    = '0;
            saturated    = 1'b0;
            string_radix = BASE_DEC;
            char_pos     = '0;
            zero_end     = '0;
            expected_conversions.delete();
        end else begin
            if (i_cfg_wr_en) radix_reg = i_cfg_wr_data;
            if (i_char_valid && i_char_ready) begin
                parse_char(i_char_data, i_char_first, i_char_last, produced, predicted);
                if (produced) expected_conversions.push_back(predicted);
            end
            if (i_res_valid && i_res_ready) begin
                seen.value      = i_res_data[63:0];
                seen.end_offset = i_res_data[79:64];
                seen.overflowed = i_res_flags[0];
                seen.converted  = i_res_flags[1];
                if (expected_conversions.size() == 0) begin
                    report_mismatch("unexpected result", seen.value, '0);
                end else begin
                    wanted = expected_conversions.pop_front();
                    if (seen.value != wanted.value)
                        report_mismatch("value", seen.value, wanted.value);
                    if (seen.overflowed != wanted.overflowed)
                        report_mismatch("overflowed", 64'(seen.overflowed),
                                        64'(wanted.overflowed));
                    if (seen.converted != wanted.converted)
                        report_mismatch("converted", 64'(seen.converted),
                                        64'(wanted.converted));
                    if (seen.end_offset != wanted.end_offset)
                        report_mismatch("end_offset", 64'(seen.end_offset),
                                        64'(wanted.end_offset));
                end
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= expected_conversions.size();
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives character strings into the streaming strtol core under a range of
// radix settings and random flow control on both streams; a checker beside
// the core predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import stoi_pkg::*;

    typedef logic [7:0] t_char_q[$];

    // The core registers each character and then each result, so a short
    // pause is enough for anything still in flight to drain.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any transaction before the run is declared hung. The
    // slowest correct gap is the longest sender gap plus the longest receiver
    // stall plus the latency; this is many times that.
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int PHASE_ITEMS   = 150;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [5:0]  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] character
    logic        s_axis_tuser  = 1'b0;  // [0] first
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // [63:0] value, [79:64] end_offset
    logic [1:0]  m_axis_tuser;          // [0] overflowed, [1] converted

    int          mismatches;
    int          pending;
    int          stall_cycles  = 0;
    // While set, neither side inserts idle cycles.
    bit          quiet_stretch = 1'b0;
    // Radix last written, used to shape well-formed numbers.
    logic [5:0]  active_radix  = BASE_DEC;

    always #5 i_clk = ~i_clk;

    string_to_signed_integer_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    strtol_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_char_valid  (s_axis_tvalid),
        .i_char_ready  (s_axis_tready),
        .i_char_data   (s_axis_tdata),
        .i_char_first  (s_axis_tuser),
        .i_char_last   (s_axis_tlast),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_flags   (m_axis_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Offers one character and holds it until the core takes the transaction.
    // A zero gap keeps tvalid high straight into the next character.
    task automatic send_char(input logic [7:0] c, input bit first, input bit last);
        int gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // The first flag goes on the opening character, the last flag on the final one.
    task automatic send_seq(input t_char_q chars, input bit with_first, input bit with_last);
        for (int i = 0; i < chars.size(); i++)
            send_char(chars[i], with_first && i == 0, with_last && i == chars.size() - 1);
    endtask

    task automatic send_text(input string s, input bit with_first, input bit with_last);
        t_char_q chars;
        for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
        send_seq(chars, with_first, with_last);
    endtask

    // Lets every predicted result arrive and the core go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The radix is only changed while the core is idle.
    task automatic set_radix(input logic [5:0] radix);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= radix;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        active_radix = radix;
    endtask

    function automatic logic [7:0] digit_char(int v);
        if (v < 10) return CHAR_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CHAR_A_LO : CHAR_A_UP) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] blank_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
    endfunction

    // Builds a well-formed number for the given radix: optional blanks, an
    // optional sign, a prefix where the radix allows one, then digits. Now and
    // then the digit run is long enough to overflow even in base 2.
    task automatic make_number(input logic [5:0] radix, output t_char_q chars);
        int digit_base;
        int sign_kind;
        int count;
        chars = {};
        repeat ($urandom_range(0, 2)) chars.push_back(blank_char());
        sign_kind = $urandom_range(0, 2);
        if (sign_kind == 1) chars.push_back(CHAR_PLUS);
        if (sign_kind == 2) chars.push_back(CHAR_MINUS);
        if (radix == BASE_AUTO) begin
            case ($urandom_range(0, 2))
                0: begin
                    chars.push_back(CHAR_ZERO);
                    chars.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
                    digit_base = BASE_HEX;
                end
                1: begin
                    chars.push_back(CHAR_ZERO);
                    digit_base = BASE_OCT;
                end
                default: digit_base = BASE_DEC;
            endcase
        end else if (radix == BASE_HEX && $urandom_range(0, 1)) begin
            chars.push_back(CHAR_ZERO);
            chars.push_back($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
            digit_base = BASE_HEX;
        end else begin
            digit_base = (radix >= BASE_MIN && radix <= BASE_MAX) ? radix : BASE_DEC;
        end
        count = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 70) : $urandom_range(0, 8);
        repeat (count) chars.push_back(digit_char($urandom_range(0, digit_base - 1)));
    endtask

    // Each phase of the random part runs under one radix; the first phases
    // cover automatic detection, the radix extremes and invalid settings.
    function automatic logic [5:0] pick_radix(int phase_idx);
        logic [5:0] plan[8];
        plan = '{BASE_AUTO, BASE_HEX, BASE_MIN, BASE_MAX, BASE_OCT, BASE_DEC, 6'd1, 6'd63};
        if (phase_idx < 8) return plan[phase_idx];
        if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
        if ($urandom_range(0, 2) == 0) return BASE_AUTO;
        return 6'($urandom_range(BASE_MIN, BASE_MAX));
    endfunction

    // The result side stalls for a random number of cycles before each
    // transaction, except during quiet stretches.
    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = quiet_stretch ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Hang detection: any transaction or register write restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_char_q chars;
        int      item_count;
        int      phase_count;
        int      phase_idx;
        int      kind;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, still at the reset radix of ten. The very first
        // string carries no first flag and must start at offset zero.
        send_text("42", 1'b0, 1'b1);
        send_text("  -123x", 1'b1, 1'b1);
        send_text("+9223372036854775807", 1'b1, 1'b1);
        send_text("-9223372036854775808", 1'b1, 1'b1);
        send_text("9223372036854775808", 1'b1, 1'b1);
        send_text("-99999999999999999999", 1'b1, 1'b1);
        chars = '{CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR, CHAR_SPACE, 8'h35};
        send_seq(chars, 1'b1, 1'b1);
        send_text("abc", 1'b1, 1'b1);
        send_text("-", 1'b1, 1'b1);
        send_text("   ", 1'b1, 1'b1);
        // A NUL ends the string; what follows it is ignored.
        send_text("12", 1'b1, 1'b0);
        send_char(8'h00, 1'b0, 1'b0);
        send_text("34", 1'b0, 1'b1);
        // A new first flag drops the unfinished string without a result.
        send_text("55", 1'b1, 1'b0);
        send_text("66", 1'b1, 1'b1);
        // Characters after a result are ignored until the next first flag.
        send_text("7 ", 1'b1, 1'b0);
        send_text("8", 1'b0, 1'b1);

        // Automatic detection: hex and octal prefixes, a lone zero and bare prefixes.
        set_radix(BASE_AUTO);
        send_text("0x1F", 1'b1, 1'b1);
        send_text("0X", 1'b1, 1'b1);
        send_text("0xg", 1'b1, 1'b1);
        send_text("0", 1'b1, 1'b1);
        send_text("08", 1'b1, 1'b1);
        send_text("0755", 1'b1, 1'b1);
        send_text("-0x8000000000000000", 1'b1, 1'b1);
        send_text("123", 1'b1, 1'b1);

        set_radix(BASE_HEX);
        send_text("0x7fffffffffffffff", 1'b1, 1'b1);
        send_text("fF", 1'b1, 1'b1);
        send_text("0xz", 1'b1, 1'b1);

        set_radix(BASE_MAX);
        send_text("zzzzzzzzzzzzz", 1'b1, 1'b1);
        send_text("Zz", 1'b1, 1'b1);

        set_radix(BASE_MIN);
        send_text("-1111", 1'b1, 1'b1);

        // Radix values that allow no digit at all.
        set_radix(6'd1);
        send_text("123", 1'b1, 1'b1);
        set_radix(6'd63);
        send_text("5", 1'b1, 1'b1);

        // Random part: mostly well-formed numbers with random content, plus
        // raw noise, truncated strings and strings sent without a first flag.
        item_count = 0;
        phase_idx  = 0;
        while (item_count < RANDOM_ITEMS) begin
            set_radix(pick_radix(phase_idx));
            phase_idx++;
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 24) == 0) quiet_stretch = ~quiet_stretch;
                kind = $urandom_range(0, 9);
                if (kind == 7) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 3) == 0);
                        phase_count++;
                    end
                end else begin
                    make_number(active_radix, chars);
                    if (kind == 8) begin
                        send_seq(chars, 1'b1, 1'b0);
                        phase_count += chars.size();
                    end else if (kind == 9) begin
                        send_seq(chars, 1'b0, 1'b1);
                        phase_count += chars.size();
                    end else begin
                        case ($urandom_range(0, 2))
                            0: ;
                            1: chars.push_back(($urandom_range(0, 3) == 0) ? 8'h00 :
                                               8'($urandom_range(0, 255)));
                            default: begin
                                chars.push_back(8'($urandom_range(0, 255)));
                                repeat ($urandom_range(1, 3))
                                    chars.push_back(8'($urandom_range(0, 255)));
                            end
                        endcase
                        send_seq(chars, 1'b1, 1'b1);
                        phase_count += chars.size();
                    end
                end
            end
            item_count += phase_count;
        end
        quiet_stretch = 1'b0;

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
